@@ src/pwm_integral_voltage_regulator_top_defines.svh @@
// ----------------------------------------------------------------------------
// pwm_integral_voltage_regulator_top_defines
// Assertion macros used by the regulator top level.
// ----------------------------------------------------------------------------
`ifndef PWM_INTEGRAL_VOLTAGE_REGULATOR_TOP_DEFINES_SVH
`define PWM_INTEGRAL_VOLTAGE_REGULATOR_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PIVR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PIVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pivr_pkg.sv @@
// ----------------------------------------------------------------------------
// pivr_pkg
// Constants, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package pivr_pkg;

  // fixed design constants
  localparam int PWM_PERIOD         = 512;
  localparam int SAMPLE_BITS        = 12;
  localparam int INTEGRATOR_DIVISOR = 8;
  localparam int TRIGGER_SHARE      = 4;

  localparam int SAMPLE_W = SAMPLE_BITS;
  localparam int GAIN_W   = 12;
  localparam int DUTY_W   = 9;
  localparam int INTEG_W  = 32;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int CNT_W    = $clog2(PROD_W);
  localparam int IDX_W    = 2;
  localparam int DATA_W   = 12;

  localparam int DIV_SHIFT  = $clog2(INTEGRATOR_DIVISOR);
  localparam int TRIG_SHIFT = $clog2(TRIGGER_SHARE);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(130);
  localparam logic [DUTY_W-1:0] LOW_RESET  = DUTY_W'(10);
  localparam logic [DUTY_W-1:0] HIGH_RESET = DUTY_W'(500);

  // register indexes
  localparam logic [IDX_W-1:0] REG_LOOP_GAIN  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_DUTY_LOW   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_DUTY_HIGH  = IDX_W'(2);

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input beat
    logic mult;      // form |error| * gain
    logic div_step;  // one restoring divide step
    logic accum;     // update integrator
    logic scale;     // form clamped compare value
    logic emit;      // load output register
  } pivr_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic sup_zero;  // captured supply sample was zero
    logic out_free;  // output register can take a new beat
  } pivr_sts_t;

endpackage

`default_nettype wire

@@ src/pivr_cfg.sv @@
// ----------------------------------------------------------------------------
// pivr_cfg
// Configuration registers: loop gain and duty limits.
// ----------------------------------------------------------------------------
`default_nettype none

module pivr_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  input  wire logic [pivr_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [pivr_pkg::DATA_W-1:0] cfg_data,
  output logic [pivr_pkg::GAIN_W-1:0]     loop_gain,
  output logic [pivr_pkg::DUTY_W-1:0]     duty_low_limit,
  output logic [pivr_pkg::DUTY_W-1:0]     duty_high_limit
);
  import pivr_pkg::*;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_gain       <= GAIN_RESET;
      duty_low_limit  <= LOW_RESET;
      duty_high_limit <= HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOOP_GAIN: loop_gain       <= cfg_data[GAIN_W-1:0];
        REG_DUTY_LOW:  duty_low_limit  <= cfg_data[DUTY_W-1:0];
        REG_DUTY_HIGH: duty_high_limit <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/pivr_ctrl.sv @@
// ----------------------------------------------------------------------------
// pivr_ctrl
// Sequencer: multiply, iterative divide, integrate, scale, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module pivr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pivr_pkg::pivr_sts_t sts,
  output pivr_pkg::pivr_cmd_t      cmd
);
  import pivr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIV,
    ST_ACCUM,
    ST_SCALE,
    ST_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

  state_t           state;
  logic [CNT_W-1:0] step_cnt;

  assign in_stall = (state != ST_IDLE);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.mult     = (state == ST_MULT);
    cmd.div_step = (state == ST_DIV);
    cmd.accum    = (state == ST_ACCUM);
    cmd.scale    = (state == ST_SCALE);
    cmd.emit     = (state == ST_EMIT) && sts.out_free;
  end

  // state and divide step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_MULT;
        end
        ST_MULT: begin
          step_cnt <= '0;
          state    <= sts.sup_zero ? ST_ACCUM : ST_DIV;
        end
        ST_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == LAST_STEP) state <= ST_ACCUM;
        end
        ST_ACCUM: state <= ST_SCALE;
        ST_SCALE: state <= ST_EMIT;
        ST_EMIT: begin
          if (sts.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/pivr_dp.sv @@
// ----------------------------------------------------------------------------
// pivr_dp
// Datapath: error magnitude, gain product, restoring divider, saturating
// integrator, compare scaling/clamp, trigger point and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pivr_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pivr_pkg::pivr_cmd_t          cmd,
  output pivr_pkg::pivr_sts_t               sts,
  input  wire logic [pivr_pkg::SAMPLE_W-1:0] command_sample,
  input  wire logic [pivr_pkg::SAMPLE_W-1:0] output_sample,
  input  wire logic [pivr_pkg::SAMPLE_W-1:0] supply_sample,
  input  wire logic [pivr_pkg::GAIN_W-1:0]   loop_gain,
  input  wire logic [pivr_pkg::DUTY_W-1:0]   duty_low_limit,
  input  wire logic [pivr_pkg::DUTY_W-1:0]   duty_high_limit,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic [pivr_pkg::DUTY_W-1:0]        pwm_compare,
  output logic [pivr_pkg::DUTY_W-1:0]        sample_trigger,
  output logic                              supply_zero
);
  import pivr_pkg::*;

  localparam int SUM_W  = INTEG_W + 1;
  localparam int TRIG_W = $clog2(PWM_PERIOD) + 2;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] ROUND_BIAS = INTEG_W'(INTEGRATOR_DIVISOR - 1);

  // captured item
  logic [SAMPLE_W-1:0] err_mag;
  logic                err_neg;
  logic [SAMPLE_W-1:0] sup;
  logic                sup_zero;

  // divider
  logic [PROD_W-1:0]   quo;
  logic [SAMPLE_W-1:0] rem;

  logic signed [INTEG_W-1:0] integrator;
  logic [DUTY_W-1:0]         cmp_r;

  // error = command - output
  logic [SAMPLE_W:0] err;
  assign err = {1'b0, command_sample} - {1'b0, output_sample};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_neg  <= err[SAMPLE_W];
      err_mag  <= err[SAMPLE_W] ? SAMPLE_W'(-err) : err[SAMPLE_W-1:0];
      sup      <= supply_sample;
      sup_zero <= (supply_sample == '0);
    end
  end

  // restoring divide step
  logic [SAMPLE_W:0] rem_sh;
  logic [SAMPLE_W:0] rem_sub;
  assign rem_sh  = {rem, quo[PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, sup};

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      quo <= PROD_W'({{(PROD_W-SAMPLE_W){1'b0}}, err_mag} *
                     {{(PROD_W-GAIN_W){1'b0}}, loop_gain});
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!rem_sub[SAMPLE_W]) begin
        rem <= rem_sub[SAMPLE_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SAMPLE_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b0};
      end
    end
  end

  // saturating integrator
  logic signed [SUM_W-1:0] step_s;
  logic signed [SUM_W-1:0] sum;
  assign step_s = err_neg ? -$signed(SUM_W'(quo)) : $signed(SUM_W'(quo));
  assign sum    = $signed({integrator[INTEG_W-1], integrator}) + step_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
    end else if (cmd.accum && !sup_zero) begin
      if (sum[SUM_W-1] != sum[SUM_W-2]) begin
        integrator <= sum[SUM_W-1] ? INTEG_MIN : INTEG_MAX;
      end else begin
        integrator <= sum[INTEG_W-1:0];
      end
    end
  end

  // integrator / divisor toward zero, then clamp (low limit first)
  logic signed [INTEG_W-1:0] integ_adj;
  logic signed [INTEG_W-1:0] scaled;
  logic signed [INTEG_W-1:0] low_s;
  logic signed [INTEG_W-1:0] high_s;
  assign integ_adj = integrator[INTEG_W-1] ? integrator + ROUND_BIAS : integrator;
  assign scaled    = integ_adj >>> DIV_SHIFT;
  assign low_s     = $signed(INTEG_W'(duty_low_limit));
  assign high_s    = $signed(INTEG_W'(duty_high_limit));

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      if (scaled < low_s) begin
        cmp_r <= duty_low_limit;
      end else if (scaled > high_s) begin
        cmp_r <= duty_high_limit;
      end else begin
        cmp_r <= scaled[DUTY_W-1:0];
      end
    end
  end

  // trigger = compare + (period - compare) / share
  logic signed [TRIG_W-1:0] trig_diff;
  logic signed [TRIG_W-1:0] trig_q;
  logic signed [TRIG_W-1:0] trig_sum;
  assign trig_diff = $signed(TRIG_W'(PWM_PERIOD)) - $signed(TRIG_W'(cmp_r));
  assign trig_q    = (trig_diff[TRIG_W-1] ?
                      trig_diff + $signed(TRIG_W'(TRIGGER_SHARE - 1)) : trig_diff)
                     >>> TRIG_SHIFT;
  assign trig_sum  = $signed(TRIG_W'(cmp_r)) + trig_q;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pwm_compare    <= cmp_r;
      sample_trigger <= trig_sum[DUTY_W-1:0];
      supply_zero    <= sup_zero;
    end
  end

  assign sts.sup_zero = sup_zero;
  assign sts.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

@@ src/pwm_integral_voltage_regulator_top.sv @@
// Sequence per input beat: multiply, 24 restoring divide steps, integrate,
//   scale, emit; the divide steps are skipped when the supply sample is zero.
// Inputs: a new item is taken only after the last one has been emitted, so
//   the 24-step restoring divider in the datapath limits the input rate.
// Reset: synchronous; integrator to zero, registers to gain 130, limits 10/500.
// ----------------------------------------------------------------------------
// pwm_integral_voltage_regulator_top
// Integral voltage regulator with supply feedforward, giving PWM compare and
// converter trigger values.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_integral_voltage_regulator_top_defines.svh"

module pwm_integral_voltage_regulator_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [pivr_pkg::SAMPLE_W-1:0] command_sample,
  input  wire logic [pivr_pkg::SAMPLE_W-1:0] output_sample,
  input  wire logic [pivr_pkg::SAMPLE_W-1:0] supply_sample,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [pivr_pkg::DUTY_W-1:0]        pwm_compare,
  output logic [pivr_pkg::DUTY_W-1:0]        sample_trigger,
  output logic                               supply_zero,
  // configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pivr_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [pivr_pkg::DATA_W-1:0]   cfg_data
);
  import pivr_pkg::*;

  pivr_cmd_t cmd;
  pivr_sts_t sts;

  logic [GAIN_W-1:0] loop_gain;
  logic [DUTY_W-1:0] duty_low_limit;
  logic [DUTY_W-1:0] duty_high_limit;

  assign cfg_ready = 1'b1;

  pivr_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .loop_gain       (loop_gain),
    .duty_low_limit  (duty_low_limit),
    .duty_high_limit (duty_high_limit)
  );

  pivr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pivr_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .command_sample  (command_sample),
    .output_sample   (output_sample),
    .supply_sample   (supply_sample),
    .loop_gain       (loop_gain),
    .duty_low_limit  (duty_low_limit),
    .duty_high_limit (duty_high_limit),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .pwm_compare     (pwm_compare),
    .sample_trigger  (sample_trigger),
    .supply_zero     (supply_zero)
  );

  // checks
  `PIVR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
  `PIVR_ASSERT_SAME(a_trig_past_cmp, out_valid, sample_trigger >= pwm_compare, "trigger before compare")
  `PIVR_ASSERT_NEXT(a_no_emit_idle, !in_stall && !out_valid, !out_valid, "result with no item")

endmodule

`default_nettype wire
